// ===== hw/rtl/integer_to_text_radix_formatter_top_macros.svh =====
// Assertion macros for the radix formatter
`ifndef INTEGER_TO_TEXT_RADIX_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_TEXT_RADIX_FORMATTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ITRF_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("itrf: implication failed");
`define ITRF_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("itrf: next-cycle check failed");
`else
`define ITRF_ASSERT_IMPL(label, a, c)
`define ITRF_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== hw/rtl/itrf_pkg.sv =====
`timescale 1ns / 1ps
package itrf_pkg;
	localparam int CHAR_W = 21;
	localparam int CHARS_PER_RESULT = 4;
	localparam int MAX_DIGITS = 64;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 21'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 21'd45;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 21'd43;
	localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;
	localparam logic [CHAR_W-1:0] CH_LC_B  = 21'd98;
	localparam logic [CHAR_W-1:0] CH_LC_O  = 21'd111;
	localparam logic [CHAR_W-1:0] CH_LC_X  = 21'd120;
	localparam logic [CHAR_W-1:0] CH_UC_B  = 21'd66;
	localparam logic [CHAR_W-1:0] CH_UC_O  = 21'd79;
	localparam logic [CHAR_W-1:0] CH_UC_X  = 21'd88;

	typedef enum logic [2:0] {
		CFG_RADIX       = 3'd0,
		CFG_DIGIT_UPPER = 3'd1,
		CFG_PREFIX_MODE = 3'd2,
		CFG_PLUS_MODE   = 3'd3,
		CFG_PAD_DIGITS  = 3'd4,
		CFG_PRECISION   = 3'd5,
		CFG_GROUP_LEN   = 3'd6,
		CFG_GROUP_CHAR  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PFX_NONE  = 2'd0,
		PFX_LOWER = 2'd1,
		PFX_UPPER = 2'd2,
		PFX_RSVD  = 2'd3
	} prefix_mode_t;

	typedef enum logic [1:0] {
		PLUS_NONE  = 2'd0,
		PLUS_SPACE = 2'd1,
		PLUS_PLUS  = 2'd2,
		PLUS_RSVD  = 2'd3
	} plus_mode_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d, input logic upper);
		logic [CHAR_W-1:0] base;
		begin
			base = upper ? 21'd55 : 21'd87;
			if (d < 6'd10)
				digit_char = CH_ZERO + {15'd0, d};
			else
				digit_char = base + {15'd0, d};
		end
	endfunction
endpackage

// ===== hw/rtl/itrf_div.sv =====
`timescale 1ns / 1ps
module itrf_div import itrf_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_ctl_t              ctl_in,
	output div_ctl_t              ctl_out,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [5:0]            divisor,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [5:0]            remainder
);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] q_q;
	logic [5:0]            rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [6:0]            trial;
	logic                  ge;

	assign trial = {rem_q, q_q[VALUE_BITS-1]};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			q_q   <= {q_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? 6'(trial - {1'b0, divisor}) : trial[5:0];
		end
	end

	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;
	assign quotient      = q_q;
	assign remainder     = rem_q;
endmodule

// ===== hw/rtl/integer_to_text_radix_formatter_top.sv =====
`timescale 1ns / 1ps
// channel  | handshake          | payload
// in       | in_valid/in_stall  | value, is_signed
// out      | out_valid/out_stall| out_char0..3, char_count, last_item
// cfg      | cfg_we             | cfg_index, cfg_data
// One value at a time; in_stall is high from acceptance until the last digit is queued.
// Each digit is the remainder of a division in the bit-serial divider; after the digits
// are generated the group alignment step runs, then each digit is read and emitted,
// along with any sign, prefix or separator characters.
// Reset clears control state and loads the register defaults.
// out_stall holds the character sequencer while an item waits in the output register.
`include "integer_to_text_radix_formatter_top_macros.svh"
module integer_to_text_radix_formatter_top import itrf_pkg::*; #(
	parameter int VALUE_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [20:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [63:0]       value,
	input  logic              is_signed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] out_char0,
	output logic [CHAR_W-1:0] out_char1,
	output logic [CHAR_W-1:0] out_char2,
	output logic [CHAR_W-1:0] out_char3,
	output logic [2:0]        char_count,
	output logic              last_item
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_MOD, ST_SIGN, ST_PFX0, ST_PFX1,
		ST_RD, ST_CH, ST_SEP
	} state_t;

	logic [5:0]        radix_q;
	logic              upper_q;
	logic [1:0]        prefix_q;
	logic [1:0]        plus_q;
	logic [6:0]        mind_q;
	logic [6:0]        prec_q;
	logic [6:0]        gsize_q;
	logic [CHAR_W-1:0] gchar_q;

	state_t                state_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [6:0]            n_q;
	logic [6:0]            pos_q;
	logic [6:0]            gcnt_q;
	logic [5:0]            digit_mem [MAX_DIGITS];
	logic [5:0]            rd_q;

	logic [CHAR_W-1:0] buf_q [CHARS_PER_RESULT];
	logic [1:0]        bcnt_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] oc_q [CHARS_PER_RESULT];
	logic [2:0]        ocnt_q;
	logic              olast_q;

	div_ctl_t              div_in, div_out;
	logic [VALUE_BITS-1:0] quot;
	logic [5:0]            rem;

	logic [5:0]            r_eff;
	logic [6:0]            md_eff;
	logic [6:0]            p_eff;
	logic [6:0]            n_nx;
	logic                  go;
	logic                  sign_on;
	logic                  pfx_on;
	logic [CHAR_W-1:0]     sign_ch;
	logic [CHAR_W-1:0]     pfx_ch;
	logic [CHAR_W-1:0]     dig_ch;
	logic                  zero_low;
	logic                  push;
	logic [CHAR_W-1:0]     push_ch;
	logic                  push_last;
	logic [VALUE_BITS-1:0] v_in;

	itrf_div #(.VALUE_BITS(VALUE_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (div_in),
		.ctl_out   (div_out),
		.dividend  (mag_q),
		.divisor   (r_eff),
		.quotient  (quot),
		.remainder (rem)
	);

	assign div_in.start = (state_q == ST_DIV_START);
	assign div_in.done  = 1'b0;

	always_comb begin
		r_eff   = (radix_q < 6'd2) ? 6'd2 : ((radix_q > 6'd36) ? 6'd36 : radix_q);
		md_eff  = (mind_q > 7'd64) ? 7'd64 : mind_q;
		p_eff   = (prec_q > 7'd64) ? 7'd64 : prec_q;
		n_nx    = n_q + 7'd1;
		v_in    = value[VALUE_BITS-1:0];
		go      = !out_valid_q || !out_stall;
		sign_on = neg_q || (plus_q == PLUS_SPACE) || (plus_q == PLUS_PLUS);
		sign_ch = neg_q ? CH_MINUS : ((plus_q == PLUS_SPACE) ? CH_SPACE : CH_PLUS);
		pfx_on  = ((prefix_q == PFX_LOWER) || (prefix_q == PFX_UPPER)) &&
			((r_eff == 6'd2) || (r_eff == 6'd8) || (r_eff == 6'd16));
		case (r_eff)
			6'd2:    pfx_ch = (prefix_q == PFX_UPPER) ? CH_UC_B : CH_LC_B;
			6'd8:    pfx_ch = (prefix_q == PFX_UPPER) ? CH_UC_O : CH_LC_O;
			default: pfx_ch = (prefix_q == PFX_UPPER) ? CH_UC_X : CH_LC_X;
		endcase
		zero_low = (p_eff != 7'd0) && (n_q > p_eff) && (pos_q < (n_q - p_eff));
		dig_ch   = ((pos_q < n_q) && !zero_low) ? digit_char(rd_q, upper_q) : CH_ZERO;
		push      = 1'b0;
		push_ch   = CH_ZERO;
		push_last = 1'b0;
		case (state_q)
			ST_SIGN: begin
				push    = go && sign_on;
				push_ch = sign_ch;
			end
			ST_PFX0: begin
				push    = go && pfx_on;
				push_ch = CH_ZERO;
			end
			ST_PFX1: begin
				push    = go;
				push_ch = pfx_ch;
			end
			ST_CH: begin
				push      = go;
				push_ch   = dig_ch;
				push_last = (pos_q == 7'd0);
			end
			ST_SEP: begin
				push    = go;
				push_ch = gchar_q;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= 6'd10;
			upper_q  <= 1'b0;
			prefix_q <= PFX_NONE;
			plus_q   <= PLUS_NONE;
			mind_q   <= '0;
			prec_q   <= '0;
			gsize_q  <= '0;
			gchar_q  <= 21'd44;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIX:       radix_q  <= cfg_data[5:0];
				CFG_DIGIT_UPPER: upper_q  <= cfg_data[0];
				CFG_PREFIX_MODE: prefix_q <= cfg_data[1:0];
				CFG_PLUS_MODE:   plus_q   <= cfg_data[1:0];
				CFG_PAD_DIGITS:  mind_q   <= cfg_data[6:0];
				CFG_PRECISION:   prec_q   <= cfg_data[6:0];
				CFG_GROUP_LEN:   gsize_q  <= cfg_data[6:0];
				CFG_GROUP_CHAR:  gchar_q  <= cfg_data;
				default:         gchar_q  <= gchar_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_WAIT && div_out.done)
			digit_mem[n_q[5:0]] <= rem;
		if (state_q == ST_RD)
			rd_q <= digit_mem[6'(pos_q - 7'd1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			n_q         <= '0;
			pos_q       <= '0;
			gcnt_q      <= '0;
			bcnt_q      <= '0;
			out_valid_q <= 1'b0;
			ocnt_q      <= 3'd1;
			olast_q     <= 1'b0;
			for (int j = 0; j < CHARS_PER_RESULT; j++) begin
				buf_q[j] <= '0;
				oc_q[j]  <= '0;
			end
		end else begin
			if (push && (bcnt_q == 2'(CHARS_PER_RESULT - 1) || push_last))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (push) begin
				if (bcnt_q == 2'(CHARS_PER_RESULT - 1) || push_last) begin
					for (int j = 0; j < CHARS_PER_RESULT; j++)
						oc_q[j] <= (j < int'(bcnt_q)) ? buf_q[j] :
							((j == int'(bcnt_q)) ? push_ch : '0);
					ocnt_q      <= {1'b0, bcnt_q} + 3'd1;
					olast_q     <= push_last;
					bcnt_q      <= '0;
				end else begin
					buf_q[bcnt_q] <= push_ch;
					bcnt_q        <= bcnt_q + 2'd1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						neg_q   <= is_signed && v_in[VALUE_BITS-1];
						mag_q   <= (is_signed && v_in[VALUE_BITS-1]) ? -v_in : v_in;
						n_q     <= '0;
						state_q <= ST_DIV_START;
					end
				end
				ST_DIV_START: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_out.done) begin
						mag_q <= quot;
						n_q   <= n_nx;
						if (quot == '0 || n_nx == 7'(MAX_DIGITS)) begin
							pos_q   <= (md_eff > n_nx) ? md_eff : n_nx;
							gcnt_q  <= (md_eff > n_nx) ? md_eff : n_nx;
							state_q <= ST_MOD;
						end else begin
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_MOD: begin
					if (gsize_q != '0 && gcnt_q >= gsize_q)
						gcnt_q <= gcnt_q - gsize_q;
					else
						state_q <= ST_SIGN;
				end
				ST_SIGN: if (!sign_on || go) state_q <= ST_PFX0;
				ST_PFX0: begin
					if (!pfx_on)
						state_q <= ST_RD;
					else if (go)
						state_q <= ST_PFX1;
				end
				ST_PFX1: if (go) state_q <= ST_RD;
				ST_RD: begin
					pos_q   <= pos_q - 7'd1;
					gcnt_q  <= (gcnt_q == '0) ? gsize_q - 7'd1 : gcnt_q - 7'd1;
					state_q <= ST_CH;
				end
				ST_CH: begin
					if (go) begin
						if (pos_q == '0)
							state_q <= ST_IDLE;
						else if (gsize_q != '0 && gcnt_q == '0)
							state_q <= ST_SEP;
						else
							state_q <= ST_RD;
					end
				end
				ST_SEP: if (go) state_q <= ST_RD;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign out_char0  = oc_q[0];
	assign out_char1  = oc_q[1];
	assign out_char2  = oc_q[2];
	assign out_char3  = oc_q[3];
	assign char_count = ocnt_q;
	assign last_item  = olast_q;

	`ITRF_ASSERT_IMPL(a_div_done_wait, div_out.done, state_q == ST_DIV_WAIT)
	`ITRF_ASSERT_IMPL(a_div_busy_wait, div_out.start, state_q == ST_DIV_WAIT)
	`ITRF_ASSERT_NEXT(a_rd_then_ch, state_q == ST_RD, state_q == ST_CH)
	`ITRF_ASSERT_IMPL(a_count_range, out_valid_q, ocnt_q != 3'd0 && ocnt_q <= 3'd4)
	`ITRF_ASSERT_IMPL(a_digits_cap, 1'b1, n_q <= 7'd64)
endmodule
